>>> rtl/core/bfp_pkg.sv
`default_nettype none

package bfp_pkg;

    localparam int SIZE_W       = 32;
    localparam int SEQ_W        = 32;
    localparam int EXT_HANDLE_W = 8;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // action codes
    localparam logic ACT_TAKE   = 1'b0;
    localparam logic ACT_RETURN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_MV_RD,
        ST_MV_WR,
        ST_EV_RD,
        ST_EV_WR,
        ST_INSERT,
        ST_RESP
    } bfp_state_t;

    // verdict of the shared size compare
    typedef struct packed {
        logic fits;
        logic better;
    } bfp_fit_t;

endpackage

`default_nettype wire

>>> rtl/core/bfp_ifs.sv
`default_nettype none

interface bfp_req_if
    import bfp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic [SIZE_W-1:0]       take_size;
    logic [EXT_HANDLE_W-1:0] ret_handle;
    logic [SIZE_W-1:0]       ret_size;

    modport source (output valid, action, take_size, ret_handle, ret_size, input ready);
    modport sink   (input valid, action, take_size, ret_handle, ret_size, output ready);
endinterface

interface bfp_rsp_if
    import bfp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [EXT_HANDLE_W-1:0] got_handle;
    logic [SIZE_W-1:0]       got_size;
    logic [SEQ_W-1:0]        seq_number;
    logic                    evicted;
    logic [EXT_HANDLE_W-1:0] evicted_handle;

    modport source (output valid, found, got_handle, got_size, seq_number, evicted,
                    evicted_handle, input ready);
    modport sink   (input valid, found, got_handle, got_size, seq_number, evicted,
                    evicted_handle, output ready);
endinterface

interface bfp_cfg_if
    import bfp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_entries;

    modport source (output valid, max_entries, input ready);
    modport sink   (input valid, max_entries, output ready);
endinterface

`default_nettype wire

>>> rtl/core/bfp_ram.sv
`default_nettype none

module bfp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  wire logic                                clk,
    input  wire logic                                we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                    wdata,
    input  wire logic                                re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bfp_fit_cmp.sv
`default_nettype none

module bfp_fit_cmp
    import bfp_pkg::*;
(
    input  wire logic [SIZE_W-1:0] take_size,
    input  wire logic [SIZE_W-1:0] cand_size,
    input  wire logic              have_best,
    input  wire logic [SIZE_W-1:0] best_size,
    output bfp_fit_t               verdict
);

    logic [SIZE_W:0] twice;

    // doubled request carries one extra bit
    assign twice          = {take_size, 1'b0};
    assign verdict.fits   = (cand_size >= take_size) && ({1'b0, cand_size} <= twice);
    assign verdict.better = !have_best || (cand_size < best_size);

endmodule

`default_nettype wire

>>> rtl/core/best_fit_buffer_pool_lru.sv
// take: the n pooled buffers are scanned one per cycle through the single pool ram read port;
//   after a hit the m entries behind it are moved up, each one read then written; an empty
//   pool skips the scan and goes straight to the result
// return: with an eviction the oldest entry is read from the ram first
// throughput: one word at a time; ready again in the cycle the result word turns valid
// reset: pool empty, sequence counter zero, limit 8; pool ram is not cleared
`default_nettype none

module best_fit_buffer_pool_lru
    import bfp_pkg::*;
#(
    parameter int POOL_DEPTH  = 8,
    parameter int HANDLE_BITS = 8
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bfp_req_if.sink    req,
    bfp_rsp_if.source  rsp,
    bfp_cfg_if.sink    cfg
);

    localparam int PW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;  // ram address
    localparam int CW = $clog2(POOL_DEPTH + 1);                     // count / logical index
    localparam int LW = ((CW > CFG_W) ? CW : CFG_W) + 1;            // limit compare
    localparam int EW = HANDLE_BITS + SIZE_W;                       // ram word

    // pool is a ring: logical slot 0 (most recent) sits at head
    function automatic logic [PW-1:0] to_phys(input logic [PW-1:0] h,
                                              input logic [CW-1:0] l);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(l);
        if (s >= (CW+1)'(POOL_DEPTH))
        begin
            s = s - (CW+1)'(POOL_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [EXT_HANDLE_W-1:0] ext_handle(input logic [HANDLE_BITS-1:0] h);
        logic [HANDLE_BITS+EXT_HANDLE_W-1:0] w;
        w = {{EXT_HANDLE_W{1'b0}}, h};
        return w[EXT_HANDLE_W-1:0];
    endfunction

    // control state
    bfp_state_t        state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [CFG_W-1:0]  max_reg;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              cmp_v_reg, cmp_v_next;
    logic              hit_reg, hit_next;
    logic              ev_reg, ev_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic                   act_reg, act_next;
    logic [SIZE_W-1:0]      req_reg, req_next;
    logic [HANDLE_BITS-1:0] rh_reg, rh_next;
    logic [SIZE_W-1:0]      rs_reg, rs_next;
    logic [CW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]          best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]      best_size_reg, best_size_next;
    logic [HANDLE_BITS-1:0] best_handle_reg, best_handle_next;
    logic [HANDLE_BITS-1:0] ev_handle_reg, ev_handle_next;

    // result word register
    logic                    found_reg;
    logic [EXT_HANDLE_W-1:0] got_handle_reg;
    logic [SIZE_W-1:0]       got_size_reg;
    logic [SEQ_W-1:0]        seq_out_reg;
    logic                    evicted_reg;
    logic [EXT_HANDLE_W-1:0] evicted_handle_reg;
    logic                    load_out;

    // ram port
    logic          ram_we, ram_re;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [SIZE_W-1:0]      rd_size;
    logic [HANDLE_BITS-1:0] rd_handle;

    logic [HANDLE_BITS+EXT_HANDLE_W-1:0] in_handle_wide;
    logic [CFG_W-1:0]  lim_eff;
    logic              need_evict;
    logic [CW-1:0]     idx_p1;
    logic [SEQ_W-1:0]  seq_inc;
    bfp_fit_t          fit;
    logic              take_acc;

    assign rd_size   = ram_rdata[SIZE_W-1:0];
    assign rd_handle = ram_rdata[EW-1:SIZE_W];

    assign in_handle_wide = {{EXT_HANDLE_W{1'b0}}, req.ret_handle} >> 0;
    assign idx_p1         = idx_reg + CW'(1);
    assign seq_inc        = seq_reg + SEQ_W'(1);

    // limit zero reads as one; a limit above the depth is caught by the full check
    assign lim_eff    = (max_reg == '0) ? CFG_W'(1) : max_reg;
    assign need_evict = (count_reg != '0) &&
                        ((LW'(count_reg) >= LW'(lim_eff)) ||
                         (count_reg == CW'(POOL_DEPTH)));

    assign req.ready = (state_reg == ST_IDLE);
    assign take_acc  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    bfp_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_DEPTH)
    ) u_bfp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared compare: one pool entry per cycle during the scan
    bfp_fit_cmp u_bfp_fit_cmp (
        .take_size (req_reg),
        .cand_size (rd_size),
        .have_best (hit_reg),
        .best_size (best_size_reg),
        .verdict   (fit)
    );

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        seq_next         = seq_reg;
        idx_next         = idx_reg;
        cmp_v_next       = 1'b0;
        hit_next         = hit_reg;
        ev_next          = ev_reg;
        act_next         = act_reg;
        req_next         = req_reg;
        rh_next          = rh_reg;
        rs_next          = rs_reg;
        cmp_idx_next     = cmp_idx_reg;
        best_idx_next    = best_idx_reg;
        best_size_next   = best_size_reg;
        best_handle_next = best_handle_reg;
        ev_handle_next   = ev_handle_reg;
        ram_we           = 1'b0;
        ram_waddr        = head_reg;
        ram_wdata        = ram_rdata;
        ram_re           = 1'b0;
        ram_raddr        = head_reg;
        load_out         = 1'b0;

        // compare the entry whose read was issued last cycle
        if (cmp_v_reg && fit.fits && fit.better)
        begin
            hit_next         = 1'b1;
            best_idx_next    = cmp_idx_reg;
            best_size_next   = rd_size;
            best_handle_next = rd_handle;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_acc)
                begin
                    act_next = req.action;
                    req_next = req.take_size;
                    rh_next  = in_handle_wide[HANDLE_BITS-1:0];
                    rs_next  = req.ret_size;
                    hit_next = 1'b0;
                    ev_next  = 1'b0;
                    idx_next = '0;
                    if (req.action == ACT_TAKE)
                    begin
                        // zero is never issued
                        seq_next = (seq_inc == '0) ? SEQ_W'(1) : seq_inc;
                        state_next = (count_reg == '0) ? ST_RESP : ST_SCAN;
                    end
                    else if (need_evict)
                    begin
                        state_next = ST_EV_RD;
                    end
                    else if (count_reg < CW'(POOL_DEPTH))
                    begin
                        state_next = ST_INSERT;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_re       = 1'b1;
                ram_raddr    = to_phys(head_reg, idx_reg);
                cmp_v_next   = 1'b1;
                cmp_idx_next = idx_reg;
                idx_next     = idx_p1;
                if (idx_p1 == count_reg)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                // last compare lands this cycle
                idx_next   = best_idx_next;
                state_next = hit_next ? ST_MV_RD : ST_RESP;
            end
            ST_MV_RD:
            begin
                if (idx_p1 < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = to_phys(head_reg, idx_p1);
                    state_next = ST_MV_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_MV_WR:
            begin
                // close the gap: entry behind moves one slot toward the head
                ram_we     = 1'b1;
                ram_waddr  = to_phys(head_reg, idx_reg);
                ram_wdata  = ram_rdata;
                idx_next   = idx_p1;
                state_next = ST_MV_RD;
            end
            ST_EV_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = to_phys(head_reg, count_reg - CW'(1));
                state_next = ST_EV_WR;
            end
            ST_EV_WR:
            begin
                ev_next        = 1'b1;
                ev_handle_next = rd_handle;
                count_next     = count_reg - CW'(1);
                state_next     = ST_INSERT;
            end
            ST_INSERT:
            begin
                head_next  = (head_reg == '0) ? PW'(POOL_DEPTH - 1) : head_reg - PW'(1);
                ram_we     = 1'b1;
                ram_waddr  = head_next;
                ram_wdata  = {rh_reg, rs_reg};
                count_next = count_reg + CW'(1);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            seq_reg       <= '0;
            max_reg       <= CFG_RESET;
            idx_reg       <= '0;
            cmp_v_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            ev_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            idx_reg       <= idx_next;
            cmp_v_reg     <= cmp_v_next;
            hit_reg       <= hit_next;
            ev_reg        <= ev_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                max_reg <= cfg.max_entries;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        req_reg         <= req_next;
        rh_reg          <= rh_next;
        rs_reg          <= rs_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_idx_reg    <= best_idx_next;
        best_size_reg   <= best_size_next;
        best_handle_reg <= best_handle_next;
        ev_handle_reg   <= ev_handle_next;
        if (load_out)
        begin
            // unused fields of each kind of result are zero
            found_reg          <= (act_reg == ACT_TAKE) && hit_reg;
            got_handle_reg     <= ((act_reg == ACT_TAKE) && hit_reg) ?
                                  ext_handle(best_handle_reg) : '0;
            got_size_reg       <= ((act_reg == ACT_TAKE) && hit_reg) ? best_size_reg : '0;
            seq_out_reg        <= (act_reg == ACT_TAKE) ? seq_reg : '0;
            evicted_reg        <= (act_reg == ACT_RETURN) && ev_reg;
            evicted_handle_reg <= ((act_reg == ACT_RETURN) && ev_reg) ?
                                  ext_handle(ev_handle_reg) : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.found          = found_reg;
    assign rsp.got_handle     = got_handle_reg;
    assign rsp.got_size       = got_size_reg;
    assign rsp.seq_number     = seq_out_reg;
    assign rsp.evicted        = evicted_reg;
    assign rsp.evicted_handle = evicted_handle_reg;

endmodule

`default_nettype wire

>>> rtl/core/bfp_checker.sv
`default_nettype none

module bfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        found,
    input wire logic [31:0] got_size,
    input wire logic [31:0] seq_number,
    input wire logic        evicted
);

    // a result word waits until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped before taken");

    // one word in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("accepted a word while busy");

    // a hit always carries a nonzero sequence number and never an eviction
    a_hit_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> (seq_number != 32'd0) && !evicted)
        else $error("hit word malformed");

    // an eviction only comes from a return
    a_evict_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> (seq_number == 32'd0) && !found && (got_size == 32'd0))
        else $error("eviction word malformed");

endmodule

bind best_fit_buffer_pool_lru bfp_checker u_bfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .found      (rsp.found),
    .got_size   (rsp.got_size),
    .seq_number (rsp.seq_number),
    .evicted    (rsp.evicted)
);

`default_nettype wire
